FILE: src/wpfe_pkg.sv
// Shared types and constants for the WS2812 PWM frame encoder.
// No dependencies; used by every module under src.
`default_nettype none

package wpfe_pkg;

   localparam int FULL_SCALE_DEF  = 255;  // brightness full scale
   localparam int QUEUE_DEPTH_DEF = 4;    // pixel queue between front and back

   localparam int BITS_PER_PIXEL  = 24;
   localparam int MAX_LATCH_SLOTS = 40;
   localparam int RECIP_SHIFT     = 24;   // fixed-point shift of the 1/FULL_SCALE factor

   localparam int BIT_CNT_W  = $clog2(BITS_PER_PIXEL);
   localparam int SLOT_CNT_W = $clog2(MAX_LATCH_SLOTS);

   // color order codes
   localparam logic [2:0] ORDER_RGB = 3'd0;
   localparam logic [2:0] ORDER_BRG = 3'd1;
   localparam logic [2:0] ORDER_BGR = 3'd2;
   localparam logic [2:0] ORDER_RBG = 3'd3;
   localparam logic [2:0] ORDER_GBR = 3'd4;
   localparam logic [2:0] ORDER_GRB = 3'd5;

   // register indexes, byte address is 4*index
   localparam logic [2:0] REG_BRIGHTNESS  = 3'd0;
   localparam logic [2:0] REG_BYTE_ORDER  = 3'd1;
   localparam logic [2:0] REG_T0_WIDTH    = 3'd2;
   localparam logic [2:0] REG_T1_WIDTH    = 3'd3;
   localparam logic [2:0] REG_LATCH_SLOTS = 3'd4;

   localparam int CSR_ADDR_W = 5;

   typedef struct packed {
      logic [7:0]  brightness;
      logic [2:0]  byte_order;
      logic [15:0] t0_width;
      logic [15:0] t1_width;
      logic [5:0]  latch_slots;
   } cfg_type;

   // one scaled, ordered pixel waiting for the bit-slot generator
   typedef struct packed {
      logic [BITS_PER_PIXEL-1:0] word;
      logic                      last;
   } pixel_type;

   typedef enum logic [1:0] {
      GEN_IDLE,
      GEN_DATA,
      GEN_LATCH
   } gen_state_type;

endpackage

`default_nettype wire

FILE: src/wpfe_csr.sv
// Configuration register file with an APB-style slave port.
// Depends on wpfe_pkg (cfg_type, register indexes).
`default_nettype none

module wpfe_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [wpfe_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [31:0]                      pwdata,
   output logic      [31:0]                      prdata,
   output logic                                  pready,
   output wpfe_pkg::cfg_type                     cfg
);

   wpfe_pkg::cfg_type cfg_ff, cfg_in;
   logic [2:0]        index;
   logic              wr_en;

   assign index  = paddr[wpfe_pkg::CSR_ADDR_W-1:2];
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            wpfe_pkg::REG_BRIGHTNESS:  cfg_in.brightness  = pwdata[7:0];
            wpfe_pkg::REG_BYTE_ORDER:  cfg_in.byte_order  = pwdata[2:0];
            wpfe_pkg::REG_T0_WIDTH:    cfg_in.t0_width    = pwdata[15:0];
            wpfe_pkg::REG_T1_WIDTH:    cfg_in.t1_width    = pwdata[15:0];
            wpfe_pkg::REG_LATCH_SLOTS: cfg_in.latch_slots = pwdata[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         wpfe_pkg::REG_BRIGHTNESS:  prdata = {24'd0, cfg_ff.brightness};
         wpfe_pkg::REG_BYTE_ORDER:  prdata = {29'd0, cfg_ff.byte_order};
         wpfe_pkg::REG_T0_WIDTH:    prdata = {16'd0, cfg_ff.t0_width};
         wpfe_pkg::REG_T1_WIDTH:    prdata = {16'd0, cfg_ff.t1_width};
         wpfe_pkg::REG_LATCH_SLOTS: prdata = {26'd0, cfg_ff.latch_slots};
         default:                   prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.brightness  <= 8'd255;
         cfg_ff.byte_order  <= wpfe_pkg::ORDER_GRB;
         cfg_ff.t0_width    <= 16'd30;
         cfg_ff.t1_width    <= 16'd60;
         cfg_ff.latch_slots <= 6'd40;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/wpfe_front.sv
// Front end: takes pixels, scales each channel by brightness/FULL_SCALE and
// reorders the bytes. Depends on wpfe_pkg.
`default_nettype none

module wpfe_front #(
   parameter int FULL_SCALE = wpfe_pkg::FULL_SCALE_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire wpfe_pkg::cfg_type   cfg,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire logic [23:0]         in_rgb,     // red, green, blue from bit 0 up
   input  wire logic                in_last,
   output logic                     push,
   output wpfe_pkg::pixel_type      push_data,
   input  wire logic                q_full
);

   localparam int            RW    = wpfe_pkg::RECIP_SHIFT + 1;
   localparam logic [RW-1:0] RECIP = RW'((1 << wpfe_pkg::RECIP_SHIFT) / FULL_SCALE);
   localparam logic [23:0]   DIV   = 24'(FULL_SCALE);

   // stage 1: raw products, stage 2: reciprocal estimate of the quotient
   logic               v1_ff, v2_ff;
   logic [15:0]        p1_ff [3];
   logic               last1_ff;
   logic [15:0]        p2_ff [3];
   logic [15:0]        q2_ff [3];
   logic               last2_ff;
   logic               adv;
   logic [7:0]         chan [3];

   assign adv      = !v2_ff || !q_full;
   assign in_ready = adv;
   assign push     = v2_ff && !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_lane
      logic [15+RW:0] est;
      logic [23:0]    back_prod;
      logic [23:0]    rem;
      logic [15:0]    quot;

      assign est       = {{RW{1'b0}}, p1_ff[i]} * {16'd0, RECIP};
      assign back_prod = {8'd0, q2_ff[i]} * DIV;
      assign rem       = {8'd0, p2_ff[i]} - back_prod;
      // estimate is low by at most one
      assign quot      = (rem >= DIV) ? q2_ff[i] + 16'd1 : q2_ff[i];
      assign chan[i]   = (quot > 16'd255) ? 8'hFF : quot[7:0];

      always_ff @(posedge clock) begin
         if (adv) begin
            p1_ff[i] <= {8'd0, in_rgb[8*i +: 8]} * {8'd0, cfg.brightness};
            p2_ff[i] <= p1_ff[i];
            q2_ff[i] <= est[wpfe_pkg::RECIP_SHIFT +: 16];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         last1_ff <= in_last;
         last2_ff <= last1_ff;
      end
   end

   // chan[0] red, chan[1] green, chan[2] blue
   always_comb begin
      push_data.last = last2_ff;
      unique case (cfg.byte_order)
         wpfe_pkg::ORDER_RGB: push_data.word = {chan[0], chan[1], chan[2]};
         wpfe_pkg::ORDER_BRG: push_data.word = {chan[2], chan[0], chan[1]};
         wpfe_pkg::ORDER_BGR: push_data.word = {chan[2], chan[1], chan[0]};
         wpfe_pkg::ORDER_RBG: push_data.word = {chan[0], chan[2], chan[1]};
         wpfe_pkg::ORDER_GBR: push_data.word = {chan[1], chan[2], chan[0]};
         default:             push_data.word = {chan[1], chan[0], chan[2]};
      endcase
   end

endmodule

`default_nettype wire

FILE: src/wpfe_queue.sv
// Small pixel queue between front end and bit-slot generator.
// Depends on wpfe_pkg (pixel_type).
`default_nettype none

module wpfe_queue #(
   parameter int DEPTH = wpfe_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire wpfe_pkg::pixel_type   push_data,
   output logic                       full,
   input  wire logic                  pop,
   output logic                       pop_valid,
   output wpfe_pkg::pixel_type        pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   wpfe_pkg::pixel_type mem [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full      = (count_ff == CW'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push || pop)
      else $error("pixel queue overflow");

endmodule

`default_nettype wire

FILE: src/wpfe_back.sv
// Bit-slot generator: turns queued pixels into PWM compare words, then the
// latch slots after a frame's last pixel. Depends on wpfe_pkg.
`default_nettype none

module wpfe_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire wpfe_pkg::cfg_type     cfg,
   input  wire logic                  q_valid,
   input  wire wpfe_pkg::pixel_type   q_data,
   output logic                       q_pop,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic [15:0]                out_cmp,
   output logic                       out_last,
   output logic                       out_done
);

   localparam int BW = wpfe_pkg::BIT_CNT_W;
   localparam int SW = wpfe_pkg::SLOT_CNT_W;
   localparam logic [BW-1:0] LAST_BIT = BW'(wpfe_pkg::BITS_PER_PIXEL - 1);
   localparam logic [5:0]    MAX_M1   = 6'(wpfe_pkg::MAX_LATCH_SLOTS - 1);

   wpfe_pkg::gen_state_type state_ff, state_in;
   logic [wpfe_pkg::BITS_PER_PIXEL-1:0] word_ff, word_in;
   logic [BW-1:0] bit_ff, bit_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic [SW-1:0] slots_m1_ff, slots_m1_in;
   logic          last_ff, last_in;
   logic          valid_ff, valid_in;
   logic [15:0]   cmp_ff, cmp_in;
   logic          lor_ff, lor_in;
   logic          done_ff, done_in;

   logic          out_adv, emit, final_slot;
   logic [15:0]   cur_cmp;
   logic          cur_lor, cur_done;
   logic [SW-1:0] load_m1;

   assign out_valid = valid_ff;
   assign out_cmp   = cmp_ff;
   assign out_last  = lor_ff;
   assign out_done  = done_ff;

   // latch slot count, saturated to the max and at least one
   always_comb begin
      if (cfg.latch_slots > MAX_M1) begin
         load_m1 = SW'(MAX_M1);
      end else if (cfg.latch_slots == 6'd0) begin
         load_m1 = '0;
      end else begin
         load_m1 = SW'(cfg.latch_slots - 6'd1);
      end
   end

   always_comb begin
      state_in    = state_ff;
      word_in     = word_ff;
      bit_in      = bit_ff;
      slot_in     = slot_ff;
      slots_m1_in = slots_m1_ff;
      last_in     = last_ff;
      valid_in    = valid_ff;
      cmp_in      = cmp_ff;
      lor_in      = lor_ff;
      done_in     = done_ff;
      cur_cmp     = 16'd0;
      cur_lor     = 1'b0;
      cur_done    = 1'b0;
      final_slot  = 1'b0;

      out_adv = !valid_ff || out_ready;
      emit    = out_adv && (state_ff != wpfe_pkg::GEN_IDLE);

      unique case (state_ff)
         wpfe_pkg::GEN_IDLE: ;
         wpfe_pkg::GEN_DATA: begin
            cur_cmp    = word_ff[wpfe_pkg::BITS_PER_PIXEL-1] ? cfg.t1_width
                                                             : cfg.t0_width;
            cur_lor    = !last_ff && (bit_ff == LAST_BIT);
            final_slot = cur_lor;
            if (emit) begin
               word_in = {word_ff[wpfe_pkg::BITS_PER_PIXEL-2:0], 1'b0};
               bit_in  = bit_ff + 1'b1;
               if (bit_ff == LAST_BIT) begin
                  slot_in  = '0;
                  state_in = last_ff ? wpfe_pkg::GEN_LATCH : wpfe_pkg::GEN_IDLE;
               end
            end
         end
         wpfe_pkg::GEN_LATCH: begin
            cur_lor    = (slot_ff == slots_m1_ff);
            cur_done   = cur_lor;
            final_slot = cur_lor;
            if (emit) begin
               slot_in = slot_ff + 1'b1;
               if (cur_lor) begin
                  state_in = wpfe_pkg::GEN_IDLE;
               end
            end
         end
         default: state_in = wpfe_pkg::GEN_IDLE;
      endcase

      // next pixel starts right behind the final slot of this one
      q_pop = q_valid && ((state_ff == wpfe_pkg::GEN_IDLE) || (emit && final_slot));
      if (q_pop) begin
         state_in    = wpfe_pkg::GEN_DATA;
         word_in     = q_data.word;
         bit_in      = '0;
         last_in     = q_data.last;
         slots_m1_in = load_m1;
      end

      if (out_adv) begin
         valid_in = emit;
         cmp_in   = cur_cmp;
         lor_in   = cur_lor;
         done_in  = cur_done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wpfe_pkg::GEN_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      bit_ff      <= bit_in;
      slot_ff     <= slot_in;
      slots_m1_ff <= slots_m1_in;
      last_ff     <= last_in;
      cmp_ff      <= cmp_in;
      lor_ff      <= lor_in;
      done_ff     <= done_in;
   end

   a_done_ends_run: assert property (@(posedge clock) disable iff (reset)
      valid_ff && done_ff |-> lor_ff && (cmp_ff == 16'd0))
      else $error("frame_done without end of run");

   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == wpfe_pkg::GEN_DATA |-> bit_ff <= LAST_BIT)
      else $error("bit counter past pixel end");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == wpfe_pkg::GEN_LATCH |-> slot_ff <= slots_m1_ff)
      else $error("latch slot counter past limit");

   a_pop_on_free: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid && (state_ff == wpfe_pkg::GEN_IDLE || emit))
      else $error("pixel popped while generator busy");

endmodule

`default_nettype wire

FILE: src/ws2812_pwm_frame_encoder_top.sv
// WS2812 PWM frame encoder: pixel stream in, one PWM compare word per bit
// slot out. Depends on wpfe_pkg, wpfe_csr, wpfe_front, wpfe_queue, wpfe_back.
//
// Each pixel (red, green, blue, last flag) is scaled per channel as
// value*brightness/FULL_SCALE truncated and saturated at 255, put in the
// configured byte order (codes 6 and 7 act as GRB), and expanded into 24
// compare words, MSB first: the T1 width for a 1 bit, the T0 width for a 0
// bit. After a pixel flagged last, latch_slots zero words follow (clamped to
// 1..40); the final one carries tuser = frame_done. tlast marks the final
// word of each pixel's run. Rate: one output word per cycle while rsp_tready
// is high and a pixel is waiting; the single bit-slot generator sets it.
// The front end (two-stage scaling pipe) runs ahead through a short pixel
// queue, so input stalls only when the queue is full and the pipe's last
// stage holds a pixel. A pixel taken into an empty block passes both scaling
// stages, the queue and the generator's state and output registers before
// its first word appears. Config writes are meant for idle periods only.
`default_nettype none

module ws2812_pwm_frame_encoder_top #(
   parameter int FULL_SCALE  = wpfe_pkg::FULL_SCALE_DEF,
   parameter int QUEUE_DEPTH = wpfe_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // pixel input
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [23:0]                      req_tdata,  // red[7:0], green[15:8], blue[23:16]
   input  wire logic                             req_tlast,  // last_pixel
   // bit-slot output
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [15:0]                           rsp_tdata,  // compare_value[15:0]
   output logic                                  rsp_tlast,  // last_of_run
   output logic [0:0]                            rsp_tuser,  // frame_done
   // register port
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [wpfe_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [31:0]                      csr_pwdata,
   output logic      [31:0]                      csr_prdata,
   output logic                                  csr_pready
);

   wpfe_pkg::cfg_type   cfg;
   wpfe_pkg::pixel_type push_data, pop_data;
   logic                push, q_full, pop, pop_valid;
   logic                done;

   assign rsp_tuser = done;

   // brightness 0x00, byte_order 0x04, t0_width 0x08, t1_width 0x0C,
   // latch_slots 0x10
   wpfe_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   wpfe_front #(
      .FULL_SCALE (FULL_SCALE)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_rgb    (req_tdata),
      .in_last   (req_tlast),
      .push      (push),
      .push_data (push_data),
      .q_full    (q_full)
   );

   wpfe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_data  (pop_data)
   );

   // output words come straight from the generator's output register
   wpfe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_valid   (pop_valid),
      .q_data    (pop_data),
      .q_pop     (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_cmp   (rsp_tdata),
      .out_last  (rsp_tlast),
      .out_done  (done)
   );

endmodule

`default_nettype wire

FILE: tb/sv/tb_ws2812_pwm_frame_encoder_top.sv
// Self-checking testbench for ws2812_pwm_frame_encoder_top: directed and random pixels,
// predicted bit-slot words compared in order. Depends on wpfe_pkg and the encoder RTL.
// No files, arguments or seeds needed.
`default_nettype none

module tb_ws2812_pwm_frame_encoder_top;
   timeunit 1ns;
   timeprecision 1ps;

   // Run sizing. The longest quiet stretch of a correct run is the receiver hold
   // below (plus a few cycles), so the watchdog limit sits well above it.
   localparam int          SCALE          = wpfe_pkg::FULL_SCALE_DEF;
   localparam int          RANDOM_PIXELS  = 250;
   localparam int          HOLD_CYCLES    = 300;
   localparam int          SETTLE_CYCLES  = 8;
   localparam int          TAIL_CYCLES    = 40;
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          MAX_REPORTS    = 10;
   localparam int          REG_INDEX_MAX  = 2**(wpfe_pkg::CSR_ADDR_W-2) - 1;
   localparam int          ORDER_CODE_MAX = 7;
   localparam logic [15:0] LATCH_PULSE    = 16'd0;

   // one bit-slot word as the block should emit it
   typedef struct packed {
      logic [15:0] pulse;
      logic        run_end;
      logic        frame_done;
   } slot_word_type;

   // ---------------------------------------------------------------------------
   // Clock, reset and block ports. Every signal the bench drives is known from time zero.
   // ---------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // red[7:0], green[15:8], blue[23:16]
   logic        req_tlast  = 1'b0; // last_pixel

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // compare_value[15:0]
   logic        rsp_tlast;         // last_of_run
   logic [0:0]  rsp_tuser;         // frame_done

   logic                            csr_psel    = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite  = 1'b0;
   logic [wpfe_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [31:0]                     csr_pwdata  = '0;
   logic [31:0]                     csr_prdata;
   logic                            csr_pready;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   ws2812_pwm_frame_encoder_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // ---------------------------------------------------------------------------
   // Shadow registers and the queue of words still owed by the block.
   // ---------------------------------------------------------------------------
   wpfe_pkg::cfg_type shadow_cfg = '{brightness: 8'd255,
                                     byte_order: wpfe_pkg::ORDER_GRB,
                                     t0_width: 16'd30, t1_width: 16'd60,
                                     latch_slots: 6'd40};
   slot_word_type owed_words[$];

   bit          send_idle     = 1'b1;  // sender draws gaps per pixel
   bit          recv_idle     = 1'b1;  // receiver draws stalls per word
   bit          hold_request  = 1'b0;  // one long receiver hold-off
   int unsigned fail_count    = 0;
   int unsigned pixels_sent   = 0;
   int unsigned frames_sent   = 0;
   int unsigned words_checked = 0;
   int unsigned csr_writes    = 0;
   int unsigned settings_used = 0;

   task automatic note_mismatch(input string what);
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
         $display("MISMATCH @%0t: %s", $realtime, what);
      end
   endtask

   // value*brightness/FULL_SCALE, truncated, clipped to a byte
   function automatic logic [7:0] scale_channel(input logic [7:0] value);
      int unsigned prod;
      prod = (int'(value) * int'(shadow_cfg.brightness)) / SCALE;
      return (prod > 255) ? 8'd255 : prod[7:0];
   endfunction

   // Expand one accepted pixel into the words it must produce.
   task automatic encode_pixel(input logic [7:0] red, green, blue, input logic last);
      logic [7:0]    sr, sg, sb;
      logic [23:0]   bits;
      int            latch_n;
      slot_word_type w;
      sr = scale_channel(red);
      sg = scale_channel(green);
      sb = scale_channel(blue);
      case (shadow_cfg.byte_order)
         wpfe_pkg::ORDER_RGB: bits = {sr, sg, sb};
         wpfe_pkg::ORDER_BRG: bits = {sb, sr, sg};
         wpfe_pkg::ORDER_BGR: bits = {sb, sg, sr};
         wpfe_pkg::ORDER_RBG: bits = {sr, sb, sg};
         wpfe_pkg::ORDER_GBR: bits = {sg, sb, sr};
         default:             bits = {sg, sr, sb};   // GRB, also the two unused codes
      endcase
      for (int i = wpfe_pkg::BITS_PER_PIXEL - 1; i >= 0; i--) begin
         w.pulse      = bits[i] ? shadow_cfg.t1_width : shadow_cfg.t0_width;
         w.run_end    = !last && (i == 0);
         w.frame_done = 1'b0;
         owed_words.push_back(w);
      end
      if (last) begin
         // latch tail: clamp to 1..MAX_LATCH_SLOTS
         latch_n = shadow_cfg.latch_slots;
         if (latch_n > wpfe_pkg::MAX_LATCH_SLOTS) latch_n = wpfe_pkg::MAX_LATCH_SLOTS;
         if (latch_n == 0) latch_n = 1;
         for (int i = 0; i < latch_n; i++) begin
            w.pulse      = LATCH_PULSE;
            w.run_end    = (i == latch_n - 1);
            w.frame_done = (i == latch_n - 1);
            owed_words.push_back(w);
         end
      end
   endtask

   function automatic void apply_register(input logic [2:0] index, input logic [31:0] data);
      case (index)
         wpfe_pkg::REG_BRIGHTNESS:  shadow_cfg.brightness  = data[7:0];
         wpfe_pkg::REG_BYTE_ORDER:  shadow_cfg.byte_order  = data[2:0];
         wpfe_pkg::REG_T0_WIDTH:    shadow_cfg.t0_width    = data[15:0];
         wpfe_pkg::REG_T1_WIDTH:    shadow_cfg.t1_width    = data[15:0];
         wpfe_pkg::REG_LATCH_SLOTS: shadow_cfg.latch_slots = data[5:0];
         default: ;   // unmapped index, write dropped
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // Bus-side helpers
   // ---------------------------------------------------------------------------
   // Setup cycle, then access cycle; the register takes it at the access edge.
   task automatic csr_write(input logic [2:0] index, input logic [31:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      apply_register(index, data);
      csr_writes++;
   endtask

   // random bits above the field, so masking in the block gets exercised
   function automatic logic [31:0] with_junk(input logic [31:0] value, input int width);
      logic [31:0] mask;
      mask = (32'd1 << width) - 32'd1;
      return ($urandom() & ~mask) | (value & mask);
   endfunction

   task automatic load_settings(input logic [7:0] bri, input logic [2:0] order,
                                input logic [15:0] zero_w, input logic [15:0] one_w,
                                input logic [5:0] slots);
      csr_write(wpfe_pkg::REG_BRIGHTNESS,  with_junk(32'(bri), 8));
      csr_write(wpfe_pkg::REG_BYTE_ORDER,  with_junk(32'(order), 3));
      csr_write(wpfe_pkg::REG_T0_WIDTH,    with_junk(32'(zero_w), 16));
      csr_write(wpfe_pkg::REG_T1_WIDTH,    with_junk(32'(one_w), 16));
      csr_write(wpfe_pkg::REG_LATCH_SLOTS, with_junk(32'(slots), 6));
      settings_used++;
   endtask

   // Offer one pixel; predict its words at the edge where it is taken.
   task automatic send_pixel(input logic [7:0] red, green, blue, input logic last);
      int unsigned gap;
      gap = send_idle ? $urandom_range(0, 7) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {blue, green, red};
      req_tlast  <= last;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      encode_pixel(red, green, blue, last);
      pixels_sent++;
      if (last) frames_sent++;
   endtask

   // Stop offering, wait for every owed word, then let the pipe go quiet.
   task automatic drain_block();
      req_tvalid <= 1'b0;
      while (owed_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_channel();
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return 8'(1 << $urandom_range(0, 7));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // Output side: receiver with random stalls plus one long hold, and the checker.
   // ---------------------------------------------------------------------------
   initial begin : word_sink
      int unsigned stall;
      forever begin
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end
         stall = recv_idle ? $urandom_range(0, 7) : 0;
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   always @(posedge clock) begin : word_checker
      slot_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         words_checked++;
         if (owed_words.size() == 0) begin
            note_mismatch($sformatf("unexpected word pulse=%0d last=%0b done=%0b",
                                    rsp_tdata, rsp_tlast, rsp_tuser[0]));
         end else begin
            want = owed_words.pop_front();
            if (rsp_tdata !== want.pulse || rsp_tlast !== want.run_end ||
                rsp_tuser[0] !== want.frame_done) begin
               note_mismatch($sformatf(
                  "word %0d: expected pulse=%0d last=%0b done=%0b, got %0d/%0b/%0b",
                  words_checked, want.pulse, want.run_end, want.frame_done,
                  rsp_tdata, rsp_tlast, rsp_tuser[0]));
            end
         end
      end
   end

   // Watchdog: a stretch as long as WATCHDOG_LIMIT with no word moving on any port ends the run.
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
            quiet = 0;
         else
            quiet++;
      end
      $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("ws2812_pwm_frame_encoder_top test failed");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------
   // Reset values: GRB order, pulses 30/60, 40 latch slots, full brightness.
   task automatic test_reset_values();
      send_pixel(8'h12, 8'h34, 8'h56, 1'b0);
      send_pixel(8'hFF, 8'h00, 8'h81, 1'b0);
      send_pixel(8'h01, 8'h80, 8'h7F, 1'b1);
      drain_block();
   endtask

   // All-zero, all-one and alternating bits with extreme pulse widths.
   task automatic test_channel_extremes();
      load_settings(8'd255, wpfe_pkg::ORDER_RGB, 16'd1, 16'hFFFF, 6'd1);
      send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
      send_pixel(8'hAA, 8'h55, 8'hAA, 1'b0);
      send_pixel(8'h55, 8'hAA, 8'h55, 1'b1);
      drain_block();
   endtask

   // Every order code, including the two unused ones that fall back to GRB.
   task automatic test_color_orders();
      for (int code = 0; code <= ORDER_CODE_MAX; code++) begin
         csr_write(wpfe_pkg::REG_BYTE_ORDER, with_junk(32'(code), 3));
         send_pixel(8'hF0, 8'h3C, 8'h0F, 1'b1);
         drain_block();
      end
   endtask

   // Dark, barely lit and half brightness; truncation shows on odd channels.
   task automatic test_brightness();
      csr_write(wpfe_pkg::REG_BYTE_ORDER, 32'(wpfe_pkg::ORDER_RGB));
      csr_write(wpfe_pkg::REG_BRIGHTNESS, 32'd0);
      send_pixel(8'hFF, 8'h80, 8'h01, 1'b1);
      drain_block();
      csr_write(wpfe_pkg::REG_BRIGHTNESS, 32'd1);
      send_pixel(8'hFF, 8'h80, 8'h01, 1'b1);
      drain_block();
      csr_write(wpfe_pkg::REG_BRIGHTNESS, 32'd128);
      send_pixel(8'hFF, 8'h81, 8'h03, 1'b1);
      drain_block();
   endtask

   // Latch tail length: zero acts as one, above the max saturates.
   // A zero-width pulse for 0 bits is passed through unchanged.
   task automatic test_latch_length();
      logic [5:0] lengths[5] = '{6'd0, 6'd40, 6'd41, 6'd63, 6'd2};
      load_settings(8'd255, wpfe_pkg::ORDER_GRB, 16'd0, 16'hFFFF, 6'd1);
      foreach (lengths[k]) begin
         csr_write(wpfe_pkg::REG_LATCH_SLOTS, with_junk(32'(lengths[k]), 6));
         send_pixel(pick_channel(), pick_channel(), pick_channel(), 1'b1);
         drain_block();
      end
   endtask

   // Writes beyond the last register must not disturb anything.
   task automatic test_spare_registers();
      for (int idx = wpfe_pkg::REG_LATCH_SLOTS + 1; idx <= REG_INDEX_MAX; idx++) begin
         csr_write(3'(idx), 32'hFFFF_FFFF);
         csr_write(3'(idx), $urandom());
      end
      send_pixel(8'hC3, 8'h5A, 8'h18, 1'b1);
      drain_block();
   endtask

   // Receiver holds off while the sender keeps pushing: the pixel queue
   // fills and req_tready drops, then everything drains in order.
   task automatic test_backpressure();
      load_settings(8'd200, wpfe_pkg::ORDER_BGR, 16'd25, 16'd50, 6'd3);
      send_idle    = 1'b0;
      recv_idle    = 1'b0;
      hold_request = 1'b1;
      for (int k = 0; k < 12; k++) begin
         send_pixel(pick_channel(), pick_channel(), pick_channel(), k == 11);
      end
      drain_block();
      send_idle = 1'b1;
      recv_idle = 1'b1;
   endtask

   // Fixed corner settings in phases 0 and 1, random ones after; then well-formed frames of
   // 1..8 pixels with random content; now and then a trailing run with no frame end.
   task automatic test_random_frames();
      int unsigned target;
      int unsigned phase;
      int unsigned frame_len;
      logic [15:0] zero_w, one_w;
      logic [5:0]  slots;
      target = pixels_sent + RANDOM_PIXELS;
      phase  = 0;
      while (pixels_sent < target) begin
         if (phase == 0) begin
            load_settings(8'd1, wpfe_pkg::ORDER_RGB, 16'd1, 16'hFFFF, 6'd1);
         end else if (phase == 1) begin
            load_settings(8'd255, 3'(ORDER_CODE_MAX), 16'hFFFF, 16'd1, 6'h3F);
         end else begin
            zero_w = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
            one_w  = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
            slots  = ($urandom_range(0, 5) == 0) ? 6'($urandom_range(0, 63))
                                                 : 6'($urandom_range(1, 6));
            load_settings(8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                          zero_w, one_w, slots);
         end
         // roughly one phase in four runs without any idling on a side
         send_idle = ($urandom_range(0, 3) != 0);
         recv_idle = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(2, 6)) begin
            frame_len = $urandom_range(1, 8);
            for (int k = 0; k < frame_len; k++) begin
               send_pixel(pick_channel(), pick_channel(), pick_channel(),
                          k == frame_len - 1);
            end
         end
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3))
               send_pixel(pick_channel(), pick_channel(), pick_channel(), 1'b0);
         end
         drain_block();
         phase++;
      end
      send_idle = 1'b1;
      recv_idle = 1'b1;
   endtask

   // ---------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------
   initial begin : main_sequence
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_channel_extremes();
      test_color_orders();
      test_brightness();
      test_latch_length();
      test_spare_registers();
      test_backpressure();
      test_random_frames();

      drain_block();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (owed_words.size() != 0) begin
         note_mismatch($sformatf("%0d words never arrived", owed_words.size()));
      end

      $display("run: %0d pixels in %0d frames, %0d slot words checked, %0d mismatches",
               pixels_sent, frames_sent, words_checked, fail_count);
      $display("run: %0d register writes over %0d settings, all orders and latch clamps",
               csr_writes, settings_used);
      if (fail_count == 0) begin
         $display("ws2812_pwm_frame_encoder_top test passed");
      end else begin
         $display("ws2812_pwm_frame_encoder_top test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: ws2812_pwm_frame_encoder_top.f
src/wpfe_pkg.sv
src/wpfe_csr.sv
src/wpfe_front.sv
src/wpfe_queue.sv
src/wpfe_back.sv
src/ws2812_pwm_frame_encoder_top.sv
tb/sv/tb_ws2812_pwm_frame_encoder_top.sv
